// File: design/smb_pkg.sv
package smb_pkg;

    // Store geometry
    localparam int STORE_BYTES  = 8192;
    localparam int LINE_COUNT   = STORE_BYTES / 8;
    localparam int ADDR_W       = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int ADDR_FIELD_W = 16;
    localparam int LINE_LSB     = 3;
    localparam int LINE_IDX_W   = ADDR_FIELD_W - LINE_LSB;
    localparam logic [LINE_IDX_W:0] LINE_LIMIT = (LINE_IDX_W + 1)'(LINE_COUNT);
    localparam logic [ADDR_W-1:0]   LAST_LINE  = ADDR_W'(LINE_COUNT - 1);

    // Bus widths
    localparam int DATA_W = 64;
    localparam int BE_W   = 8;
    localparam int ERR_W  = 2;
    localparam int WORD_W = 32;

    // Response codes
    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DOUBLE = 2'd2;

    // Access direction
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Legal byte enable patterns
    localparam logic [BE_W-1:0] BE_B0 = 8'h01;
    localparam logic [BE_W-1:0] BE_B1 = 8'h02;
    localparam logic [BE_W-1:0] BE_B2 = 8'h04;
    localparam logic [BE_W-1:0] BE_B3 = 8'h08;
    localparam logic [BE_W-1:0] BE_B4 = 8'h10;
    localparam logic [BE_W-1:0] BE_B5 = 8'h20;
    localparam logic [BE_W-1:0] BE_B6 = 8'h40;
    localparam logic [BE_W-1:0] BE_B7 = 8'h80;
    localparam logic [BE_W-1:0] BE_H0 = 8'h03;
    localparam logic [BE_W-1:0] BE_H1 = 8'h0C;
    localparam logic [BE_W-1:0] BE_H2 = 8'h30;
    localparam logic [BE_W-1:0] BE_H3 = 8'hC0;
    localparam logic [BE_W-1:0] BE_W0 = 8'h0F;
    localparam logic [BE_W-1:0] BE_W1 = 8'hF0;

    // Semaphore values
    localparam logic [WORD_W-1:0] SEM_FREE   = 32'd0;
    localparam logic [WORD_W-1:0] SEM_LOCKED = 32'd1;
    localparam logic [WORD_W-1:0] SEM_TWICE  = 32'd2;

    typedef enum logic [1:0] {
        LANE_NONE,
        LANE_BYTE,
        LANE_HALF,
        LANE_WORD
    } lane_size_t;

    // Outcome of one access against one line
    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [ERR_W-1:0]  err;
        logic              store;
        logic [DATA_W-1:0] line;
    } lane_res_t;

    function automatic lane_size_t lane_size(input logic [BE_W-1:0] be);
        lane_size_t sz;
        case (be)
            BE_B0, BE_B1, BE_B2, BE_B3,
            BE_B4, BE_B5, BE_B6, BE_B7: sz = LANE_BYTE;
            BE_H0, BE_H1, BE_H2, BE_H3: sz = LANE_HALF;
            BE_W0, BE_W1:               sz = LANE_WORD;
            default:                    sz = LANE_NONE;
        endcase
        return sz;
    endfunction

    // One enable bit per byte turned into a bit mask
    function automatic logic [DATA_W-1:0] byte_mask(input logic [BE_W-1:0] be);
        logic [DATA_W-1:0] m;
        for (int k = 0; k < BE_W; k++)
        begin
            m[k*8 +: 8] = {8{be[k]}};
        end
        return m;
    endfunction

endpackage

// File: design/smb_ram.sv
module smb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                             clk,
    input  logic                                             we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     waddr,
    input  logic [WIDTH-1:0]                                 wdata,
    input  logic                                             re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     raddr,
    output logic [WIDTH-1:0]                                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/smb_lane_unit.sv
module smb_lane_unit (
    input  logic                          opcode,
    input  logic                          in_range,
    input  logic [smb_pkg::BE_W-1:0]      byte_enable,
    input  logic [smb_pkg::DATA_W-1:0]    write_data,
    input  logic [smb_pkg::DATA_W-1:0]    old_line,
    output smb_pkg::lane_res_t            res
);

    import smb_pkg::*;

    lane_size_t        size;
    logic [DATA_W-1:0] mask;
    logic [WORD_W-1:0] old_word;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] put_word;
    logic [WORD_W-1:0] ret_word;
    logic [DATA_W-1:0] kept;
    logic              upper;

    assign size     = lane_size(byte_enable);
    assign mask     = byte_mask(byte_enable);
    assign upper    = !byte_enable[0];
    assign old_word = upper ? old_line[DATA_W-1:WORD_W] : old_line[WORD_W-1:0];
    assign new_word = upper ? write_data[DATA_W-1:WORD_W] : write_data[WORD_W-1:0];
    assign kept     = old_line & ~mask;

    // Semaphore value written and value returned
    always_comb
    begin
        if (opcode == OP_WRITE)
        begin
            put_word = (new_word == SEM_LOCKED && old_word == SEM_LOCKED) ? SEM_TWICE : new_word;
        end
        else
        begin
            put_word = SEM_LOCKED;
        end
        ret_word = (old_word == SEM_TWICE) ? SEM_LOCKED : old_word;
    end

    // Access outcome
    always_comb
    begin
        res.rdata = '0;
        res.err   = ERR_OK;
        res.store = 1'b0;
        res.line  = old_line;
        if (!in_range || size == LANE_NONE)
        begin
            res.err = ERR_BAD;
        end
        else if (size != LANE_WORD)
        begin
            if (opcode == OP_WRITE)
            begin
                res.store = 1'b1;
                res.line  = kept | (write_data & mask);
            end
            else
            begin
                res.rdata = old_line & mask;
            end
        end
        else if (opcode == OP_WRITE)
        begin
            if (new_word == SEM_LOCKED && old_word == SEM_TWICE)
            begin
                res.err = ERR_DOUBLE;
            end
            else
            begin
                res.store = 1'b1;
                res.line  = kept | (upper ? {put_word, {WORD_W{1'b0}}}
                                          : {{WORD_W{1'b0}}, put_word});
            end
        end
        else
        begin
            res.rdata = upper ? {ret_word, {WORD_W{1'b0}}} : {{WORD_W{1'b0}}, ret_word};
            if (old_word == SEM_FREE)
            begin
                res.store = 1'b1;
                res.line  = kept | (upper ? {put_word, {WORD_W{1'b0}}}
                                          : {{WORD_W{1'b0}}, put_word});
            end
        end
    end

endmodule

// File: design/semaphore_memory_bank.sv
// Bus slave over a store of LINE_COUNT 64-bit lines (1024 as built) with
// test-and-set semaphores in the 32-bit lanes. After reset the block clears
// the store, one line per cycle; in_stall stays high during that pass.
// After it, one transfer is accepted per cycle while out_stall does not hold
// the pipeline. The store RAM reads the line as the access is accepted; the
// next stage modifies it, writes it back and loads the result register. A
// write-back line is forwarded to the next access when that access reads
// the same line.
module semaphore_memory_bank (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [smb_pkg::ADDR_FIELD_W-1:0]  address,
    input  logic [smb_pkg::BE_W-1:0]          byte_enable,
    input  logic [smb_pkg::DATA_W-1:0]        write_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [smb_pkg::DATA_W-1:0]        read_data,
    output logic [smb_pkg::ERR_W-1:0]         error_code
);

    import smb_pkg::*;

    logic                  clear_reg;
    logic                  clear_next;
    logic [ADDR_W-1:0]     clear_cnt_reg;
    logic [ADDR_W-1:0]     clear_cnt_next;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_opcode_reg;
    logic [LINE_IDX_W-1:0] s1_line_reg;
    logic [BE_W-1:0]       s1_be_reg;
    logic [DATA_W-1:0]     s1_wdata_reg;

    logic                  fwd_valid_reg;
    logic                  fwd_valid_next;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [DATA_W-1:0]     fwd_data_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_W-1:0]     read_data_reg;
    logic [ERR_W-1:0]      error_code_reg;

    logic                  in_ready;
    logic                  in_xfer;
    logic                  s1_fire;
    logic                  s1_in_range;
    logic [ADDR_W-1:0]     s1_addr;
    logic [DATA_W-1:0]     ram_rdata;
    logic [DATA_W-1:0]     old_line;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    lane_res_t             res;

    // Handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_ready = !clear_reg && (!s1_valid_reg || s1_fire);
    assign in_xfer  = in_valid && in_ready;
    assign in_stall = !in_ready;

    assign s1_addr     = s1_line_reg[ADDR_W-1:0];
    assign s1_in_range = {1'b0, s1_line_reg} < LINE_LIMIT;

    // Use the line from the last write-back when the RAM read missed it
    assign old_line = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : ram_rdata;

    // Store write port: clearing pass, then write-back
    assign ram_we    = clear_reg || (s1_fire && res.store);
    assign ram_waddr = clear_reg ? clear_cnt_reg : s1_addr;
    assign ram_wdata = clear_reg ? '0 : res.line;

    smb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (address[LINE_LSB +: ADDR_W]),
        .rdata (ram_rdata)
    );

    smb_lane_unit u_lane (
        .opcode      (s1_opcode_reg),
        .in_range    (s1_in_range),
        .byte_enable (s1_be_reg),
        .write_data  (s1_wdata_reg),
        .old_line    (old_line),
        .res         (res)
    );

    // Next-state logic
    always_comb
    begin
        clear_next     = clear_reg;
        clear_cnt_next = clear_cnt_reg;
        if (clear_reg)
        begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == LAST_LINE)
            begin
                clear_next = 1'b0;
            end
        end

        s1_valid_next = in_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        fwd_valid_next = s1_fire ? res.store : fwd_valid_reg;

        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clear_cnt_reg <= clear_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_opcode_reg <= opcode;
            s1_line_reg   <= address[ADDR_FIELD_W-1:LINE_LSB];
            s1_be_reg     <= byte_enable;
            s1_wdata_reg  <= write_data;
        end
        if (s1_fire && res.store)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= res.line;
        end
        if (s1_fire)
        begin
            read_data_reg  <= res.rdata;
            error_code_reg <= res.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign error_code = error_code_reg;

endmodule
